### sv/sfpq_pkg.sv
`default_nettype none

package sfpq_pkg;

  // Field widths of one transaction.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned COST_W  = 32;
  localparam int unsigned COUNT_W = 7;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 64;

  // Register map.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_GOAL_ID = 1'b0;

  // Operation codes carried in the lowest bits of the input transaction.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_ADD   = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REDUCE
  } state_e;

  // One frontier entry.
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [ID_W-1:0]   id;
  } fq_entry_t;

  // Broadcast controls for the frontier cells.
  typedef struct packed {
    logic push;
    logic pop;
    logic query;
  } fc_ctrl_t;

  // Broadcast controls for the explored cells.
  typedef struct packed {
    logic add;
    logic query;
  } ec_ctrl_t;

endpackage

`default_nettype wire

### sv/sfpq_fcell.sv
`default_nettype none

// One slot of the sorted frontier. On a push every slot compares its cost
// with the new cost at once; a slot holding a higher cost takes its left
// neighbor's entry, and the slot at the insertion point takes the new entry.
// On a pop every slot takes its right neighbor's entry.
module sfpq_fcell
  import sfpq_pkg::*;
(
  input  wire             clk_i,
  input  wire fc_ctrl_t   ctrl_i,
  input  wire fq_entry_t  new_i,
  input  wire logic       occ_i,
  input  wire logic       tail_i,
  input  wire fq_entry_t  left_i,
  input  wire logic       left_gt_i,
  input  wire fq_entry_t  right_i,
  output fq_entry_t       entry_o,
  output logic            gt_o,
  output logic            match_o
);

  fq_entry_t entry_q;
  logic      match_q;

  // Held entry is more expensive than the incoming one: it moves right.
  assign gt_o = occ_i && (entry_q.cost > new_i.cost);

  // Entry storage: shift right on push from the insertion point, left on pop.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && (gt_o || tail_i)) begin
      entry_q <= left_gt_i ? left_i : new_i;
    end else if (ctrl_i.pop) begin
      entry_q <= right_i;
    end
  end

  // Membership hit, taken when a query is broadcast.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.query) begin
      match_q <= occ_i && (entry_q.id == new_i.id);
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

### sv/sfpq_ecell.sv
`default_nettype none

// One slot of the explored set. New ids enter at the first slot and the
// whole row moves one place on each add; order does not matter for lookup.
module sfpq_ecell
  import sfpq_pkg::*;
(
  input  wire             clk_i,
  input  wire ec_ctrl_t   ctrl_i,
  input  wire [ID_W-1:0]  key_i,
  input  wire logic       occ_i,
  input  wire [ID_W-1:0]  left_i,
  output logic [ID_W-1:0] id_o,
  output logic            match_o
);

  logic [ID_W-1:0] id_q;
  logic            match_q;

  // Shift one place on each add.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.add) begin
      id_q <= left_i;
    end
  end

  // Membership hit, taken when a query is broadcast.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.query) begin
      match_q <= occ_i && (id_q == key_i);
    end
  end

  assign id_o    = id_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

### sv/search_frontier_priority_queue_core.sv
// Frontier and explored lists for a best-first graph search.
// Input stream: one transaction carries an operation (push, pop, add
// explored, query), a node id and a Q16.16 cost. Output stream: exactly one
// result transaction per input transaction, in order. The user must set
// the goal id through the APB port only while the block is idle; the block
// does not enforce it. The frontier is a row of FRONTIER_DEPTH cells kept
// sorted by cost; a push or a pop moves all affected cells at once. The
// explored set is a row of EXPLORED_DEPTH cells shifted on each add.
// Push, pop and add load their result into the output register from the
// execute state once the output is free. A query first has every cell
// register its match in the execute state, then the hits are ORed together
// in the reduce state before the result is loaded.
// Reset empties both lists and clears the goal id; no clearing pass runs.
// A finished result sits in the output register; the next transaction is
// accepted while it waits, and that transaction's update holds until the
// receiver takes the waiting result.
`default_nettype none

module search_frontier_priority_queue_core
  import sfpq_pkg::*;
#(
  parameter int unsigned FRONTIER_DEPTH = 64,
  parameter int unsigned EXPLORED_DEPTH = 64
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // cmd [1:0], node_id [17:2], cost [49:18], zero [55:50]
  input  wire [IN_DATA_W-1:0]   s_axis_tdata_i,
  input  wire                   s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // out_node_id [15:0], out_cost [47:16], found [48], in_frontier [49],
  // in_explored [50], is_goal [51], overflow [52], frontier_count [59:53],
  // zero [63:60]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tvalid_o,
  input  wire                   m_axis_tready_i,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire [APB_ADDR_W-1:0]  paddr,
  input  wire [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned FCNT_W = $clog2(FRONTIER_DEPTH + 1);
  localparam int unsigned ECNT_W = $clog2(EXPLORED_DEPTH + 1);

  // Configuration register.
  logic [ID_W-1:0] goal_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_GOAL_ID)) begin
      goal_q <= pwdata[ID_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_GOAL_ID) begin
      prdata = {{(APB_DATA_W-ID_W){1'b0}}, goal_q};
    end
  end

  // Captured transaction.
  cmd_e            cmd_q;
  logic [ID_W-1:0] id_q;
  logic [COST_W-1:0] cost_q;

  state_e state_q, state_d;
  logic   in_fire;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= cmd_e'(s_axis_tdata_i[CMD_W-1:0]);
      id_q   <= s_axis_tdata_i[CMD_W +: ID_W];
      cost_q <= s_axis_tdata_i[CMD_W+ID_W +: COST_W];
    end
  end

  // Fill counts.
  logic [FCNT_W-1:0] fcnt_q, fcnt_d;
  logic [ECNT_W-1:0] ecnt_q, ecnt_d;
  logic f_full, f_empty, e_full;

  assign f_full  = (fcnt_q == FCNT_W'(FRONTIER_DEPTH));
  assign f_empty = (fcnt_q == '0);
  assign e_full  = (ecnt_q == ECNT_W'(EXPLORED_DEPTH));

  // Frontier cell row.
  fc_ctrl_t  fctrl;
  fq_entry_t new_entry;
  fq_entry_t f_entry [FRONTIER_DEPTH];
  logic [FRONTIER_DEPTH-1:0] f_gt;
  logic [FRONTIER_DEPTH-1:0] f_match;

  assign new_entry.cost = cost_q;
  assign new_entry.id   = id_q;

  for (genvar i = 0; i < FRONTIER_DEPTH; i++) begin : g_fcell
    fq_entry_t left_e, right_e;
    logic      left_gt;

    if (i == 0) begin : g_first
      assign left_e  = new_entry;
      assign left_gt = 1'b0;
    end else begin : g_inner
      assign left_e  = f_entry[i-1];
      assign left_gt = f_gt[i-1];
    end

    if (i == FRONTIER_DEPTH - 1) begin : g_last
      assign right_e = f_entry[i];
    end else begin : g_mid
      assign right_e = f_entry[i+1];
    end

    sfpq_fcell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (fctrl),
      .new_i     (new_entry),
      .occ_i     (FCNT_W'(i) < fcnt_q),
      .tail_i    (FCNT_W'(i) == fcnt_q),
      .left_i    (left_e),
      .left_gt_i (left_gt),
      .right_i   (right_e),
      .entry_o   (f_entry[i]),
      .gt_o      (f_gt[i]),
      .match_o   (f_match[i])
    );
  end

  // Explored cell row.
  ec_ctrl_t        ectrl;
  logic [ID_W-1:0] e_id [EXPLORED_DEPTH];
  logic [EXPLORED_DEPTH-1:0] e_match;

  for (genvar i = 0; i < EXPLORED_DEPTH; i++) begin : g_ecell
    logic [ID_W-1:0] left_id;

    if (i == 0) begin : g_first
      assign left_id = id_q;
    end else begin : g_inner
      assign left_id = e_id[i-1];
    end

    sfpq_ecell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ectrl),
      .key_i   (id_q),
      .occ_i   (ECNT_W'(i) < ecnt_q),
      .left_i  (left_id),
      .id_o    (e_id[i]),
      .match_o (e_match[i])
    );
  end

  // Output register.
  logic              out_valid_q;
  logic              out_free;
  logic              out_load;
  logic [ID_W-1:0]   o_id_d, o_id_q;
  logic [COST_W-1:0] o_cost_d, o_cost_q;
  logic              o_found_d, o_found_q;
  logic              o_inf_d, o_inf_q;
  logic              o_inx_d, o_inx_q;
  logic              o_goal_d, o_goal_q;
  logic              o_ovf_d, o_ovf_q;
  logic [FCNT_W+COUNT_W-1:0] cnt_ext;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign cnt_ext  = {{COUNT_W{1'b0}}, fcnt_d};

  // Sequencer: one operation at a time, result written when the output frees.
  always_comb begin
    state_d   = state_q;
    fctrl     = '0;
    ectrl     = '0;
    fcnt_d    = fcnt_q;
    ecnt_d    = ecnt_q;
    out_load  = 1'b0;
    o_id_d    = '0;
    o_cost_d  = '0;
    o_found_d = 1'b0;
    o_inf_d   = 1'b0;
    o_inx_d   = 1'b0;
    o_goal_d  = 1'b0;
    o_ovf_d   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd_q == CMD_QUERY) begin
          fctrl.query = 1'b1;
          ectrl.query = 1'b1;
          state_d     = ST_REDUCE;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          unique case (cmd_q)
            CMD_PUSH: begin
              if (f_full) begin
                o_ovf_d = 1'b1;
              end else begin
                fctrl.push = 1'b1;
                fcnt_d     = fcnt_q + 1'b1;
              end
            end
            CMD_POP: begin
              if (!f_empty) begin
                fctrl.pop = 1'b1;
                fcnt_d    = fcnt_q - 1'b1;
                o_id_d    = f_entry[0].id;
                o_cost_d  = f_entry[0].cost;
                o_found_d = 1'b1;
                o_goal_d  = (f_entry[0].id == goal_q);
              end
            end
            CMD_ADD: begin
              if (e_full) begin
                o_ovf_d = 1'b1;
              end else begin
                ectrl.add = 1'b1;
                ecnt_d    = ecnt_q + 1'b1;
              end
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
        end
      end
      ST_REDUCE: begin
        if (out_free) begin
          out_load = 1'b1;
          o_inf_d  = |f_match;
          o_inx_d  = |e_match;
          o_goal_d = (id_q == goal_q);
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fcnt_q      <= '0;
      ecnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fcnt_q  <= fcnt_d;
      ecnt_q  <= ecnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_id_q    <= o_id_d;
      o_cost_q  <= o_cost_d;
      o_found_q <= o_found_d;
      o_inf_q   <= o_inf_d;
      o_inx_q   <= o_inx_d;
      o_goal_q  <= o_goal_d;
      o_ovf_q   <= o_ovf_d;
    end
  end

  logic [COUNT_W-1:0] o_cnt_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_cnt_q <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, o_cnt_q, o_ovf_q, o_goal_q, o_inx_q, o_inf_q,
                            o_found_q, o_cost_q, o_id_q};

endmodule

`default_nettype wire
